// ===== rtl/bale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and constants for the bounded array-list editor.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 9;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 9;
  localparam int LEN_W   = 9;
  localparam int POS_W   = 13;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_ERASE  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
  } cell_ctl_t;

endpackage

// ===== rtl/bounded_array_list_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_editor
// Bounded list of words with append runs, insert, range erase and read,
// stored in a chain of slot cells that shift toward their neighbors.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                      | tuser  | tlast
// in_     | in  | index[8:0] value[40:9] count[49:41]     | func   | run_end
// out_    | out | list_length[8:0] read_data[40:9]        | status | -
//
// Append, insert, read and a non-shifting erase: the result is registered as the beat is taken.
// Erase that closes a gap: the cell chain moves one slot per cycle in a shift
// state. No new beat is taken while that shift runs.
// A new beat is taken when the result register is empty or drains that cycle.
// Reset clears count and run state; the word store stays undefined.
// ----------------------------------------------------------------------------
module bounded_array_list_editor #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bale_pkg::IN_TDATA_W-1:0]    in_tdata,  // index, value, count
  input  logic [bale_pkg::FUNC_W-1:0]        in_tuser,  // func
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bale_pkg::OUT_TDATA_W-1:0]   out_tdata, // list_length, read_data
  output logic                               out_tuser  // status
);
  import bale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;

  typedef enum logic {S_IDLE, S_SHIFT} state_t;

  state_t              state_r;
  logic [CW-1:0]       used_r;
  logic                run_active_r;
  logic                run_accepted_r;
  logic [CNT_W-1:0]    shift_cnt_r;
  logic [POS_W-1:0]    erase_pos_r;
  logic [XW-1:0]       pend_used_r;
  logic                out_valid_r;
  logic                out_status_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [VAL_W-1:0]    out_rd_r;

  func_t               func;
  logic [IDX_W-1:0]    idx;
  logic [VAL_W-1:0]    value;
  logic [CNT_W-1:0]    cnt;
  logic [XW-1:0]       idx_x;
  logic [XW-1:0]       cnt_x;
  logic [XW-1:0]       used_x;
  logic                in_fire;
  logic                acc_run;

  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rd_word;
  logic [VAL_W-1:0]     rd32;
  cell_ctl_t            ctl;

  logic [WORD_BITS-1:0] cell_q  [CAPACITY];
  logic [WORD_BITS-1:0] cell_rd [CAPACITY];

  assign func   = func_t'(in_tuser);
  assign idx    = in_tdata[8:0];
  assign value  = in_tdata[40:9];
  assign cnt    = in_tdata[49:41];
  assign idx_x  = XW'(idx);
  assign cnt_x  = XW'(cnt);
  assign used_x = XW'(used_r);

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign acc_run = run_active_r ? run_accepted_r
                                : ((used_x + cnt_x) <= XW'(CAPACITY));

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      wdata[b] = (b < VAL_W) ? value[b] : value[VAL_W-1];
    end
    rd_word = '0;
    for (int c = 0; c < CAPACITY; c++) begin
      rd_word = rd_word | cell_rd[c];
    end
    for (int b = 0; b < VAL_W; b++) begin
      rd32[b] = (b < WORD_BITS) ? rd_word[b] : 1'b0;
    end
  end

  always_comb begin
    ctl.op  = CELL_HOLD;
    ctl.pos = POS_W'(idx);
    if (state_r == S_SHIFT) begin
      ctl.op  = CELL_ERASE;
      ctl.pos = erase_pos_r;
    end else if (in_fire) begin
      unique case (func)
        FUNC_APPEND: begin
          ctl.pos = POS_W'(used_r);
          if (acc_run && (used_x < XW'(CAPACITY))) ctl.op = CELL_WRITE;
        end
        FUNC_INSERT: begin
          if (!((idx_x > used_x) || (used_x >= XW'(CAPACITY)))) ctl.op = CELL_INSERT;
        end
        FUNC_ERASE:  ctl.op = CELL_HOLD;
        FUNC_READ:   ctl.op = CELL_HOLD;
        default:     ctl.op = CELL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bale_cell #(
      .POS       (g),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wdata   (wdata),
      .lo_data (cell_q[(g == 0) ? 0 : g - 1]),
      .hi_data (cell_q[(g == CAPACITY - 1) ? g : g + 1]),
      .data_o  (cell_q[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      used_r         <= '0;
      run_active_r   <= 1'b0;
      run_accepted_r <= 1'b0;
      out_valid_r    <= 1'b0;
      shift_cnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (func != FUNC_APPEND) run_active_r <= 1'b0;
            unique case (func)
              FUNC_APPEND: begin
                out_valid_r    <= 1'b1;
                out_rd_r       <= '0;
                run_active_r   <= !in_tlast;
                run_accepted_r <= acc_run;
                if (acc_run && (used_x < XW'(CAPACITY))) begin
                  used_r       <= CW'(used_x + XW'(1));
                  out_status_r <= 1'b0;
                  out_len_r    <= LEN_W'(used_x + XW'(1));
                end else begin
                  out_status_r <= 1'b1;
                  out_len_r    <= LEN_W'(used_r);
                end
              end
              FUNC_INSERT: begin
                out_valid_r <= 1'b1;
                out_rd_r    <= '0;
                if ((idx_x > used_x) || (used_x >= XW'(CAPACITY))) begin
                  out_status_r <= 1'b1;
                  out_len_r    <= LEN_W'(used_r);
                end else begin
                  used_r       <= CW'(used_x + XW'(1));
                  out_status_r <= 1'b0;
                  out_len_r    <= LEN_W'(used_x + XW'(1));
                end
              end
              FUNC_ERASE: begin
                out_status_r <= 1'b0;
                out_rd_r     <= '0;
                if (idx_x >= used_x) begin
                  out_valid_r <= 1'b1;
                  out_len_r   <= LEN_W'(used_r);
                end else if ((idx_x + cnt_x) >= used_x) begin
                  out_valid_r <= 1'b1;
                  used_r      <= CW'(idx_x);
                  out_len_r   <= LEN_W'(idx_x);
                end else if (cnt != '0) begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_SHIFT;
                  shift_cnt_r <= cnt;
                  erase_pos_r <= POS_W'(idx);
                  pend_used_r <= used_x - cnt_x;
                end else begin
                  out_valid_r <= 1'b1;
                  out_len_r   <= LEN_W'(used_r);
                end
              end
              FUNC_READ: begin
                out_valid_r <= 1'b1;
                out_len_r   <= LEN_W'(used_r);
                if (idx_x >= used_x) begin
                  out_status_r <= 1'b1;
                  out_rd_r     <= '0;
                end else begin
                  out_status_r <= 1'b0;
                  out_rd_r     <= rd32;
                end
              end
              default: out_status_r <= 1'b1;
            endcase
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_SHIFT: begin
          shift_cnt_r <= shift_cnt_r - CNT_W'(1);
          if (shift_cnt_r == CNT_W'(1)) begin
            state_r      <= S_IDLE;
            used_r       <= CW'(pend_used_r);
            out_valid_r  <= 1'b1;
            out_status_r <= 1'b0;
            out_rd_r     <= '0;
            out_len_r    <= LEN_W'(pend_used_r);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_TDATA_W - LEN_W - VAL_W)'(0), out_rd_r, out_len_r};

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(used_r) <= XW'(CAPACITY))
    else $error("used count above capacity");

  a_shift_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> !in_tready)
    else $error("input taken during shift");

  a_shift_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (shift_cnt_r != '0))
    else $error("shift with zero count");

  a_shift_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> !out_valid_r)
    else $error("result pending during shift");

  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && state_r == S_IDLE) |-> (out_len_r == LEN_W'(used_r)))
    else $error("reported length differs from count");
`endif

endmodule

// ===== rtl/bale_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_cell
// One list slot: holds a word, takes a neighbor's word on shifts, drives its
// word onto the read bus when selected.
// ----------------------------------------------------------------------------
module bale_cell #(
  parameter int POS       = 0,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  bale_pkg::cell_ctl_t   ctl,
  input  logic [WORD_BITS-1:0]  wdata,
  input  logic [WORD_BITS-1:0]  lo_data,
  input  logic [WORD_BITS-1:0]  hi_data,
  output logic [WORD_BITS-1:0]  data_o,
  output logic [WORD_BITS-1:0]  rd_o
);
  import bale_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic                 at_pos;
  logic                 above_pos;

  assign at_pos    = (ctl.pos == MY_POS);
  assign above_pos = (MY_POS > ctl.pos);

  always_comb begin
    word_nxt = word_r;
    unique case (ctl.op)
      CELL_HOLD:   word_nxt = word_r;
      CELL_WRITE:  if (at_pos) word_nxt = wdata;
      CELL_INSERT: begin
        if (at_pos) word_nxt = wdata;
        else if (above_pos) word_nxt = lo_data;
      end
      CELL_ERASE:  if (at_pos || above_pos) word_nxt = hi_data;
      default:     word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign data_o = word_r;
  assign rd_o   = at_pos ? word_r : '0;

endmodule
